### rtl/rsp_pkg.sv
// Shared definitions for the Reed-Solomon parity encoder.
// Holds GF(256) arithmetic helpers and the control bundle passed to each cell.
// No dependencies.
package rsp_pkg;

    localparam int unsigned SymW = 8;
    localparam int unsigned CountW = 6;
    localparam logic [SymW-1:0] FieldPoly = 8'h1d;
    localparam logic [CountW-1:0] CountReset = 6'd10;

    typedef logic [SymW-1:0] sym_t;

    typedef struct packed {
        logic gen_clear;
        logic gen_step;
        logic data_step;
        logic load_out;
        logic shift_out;
    } rsp_ctrl_t;

    function automatic sym_t gf_xtime(input sym_t a);
        sym_t r;
        r = {a[SymW-2:0], 1'b0};
        if (a[SymW-1]) begin
            r = r ^ FieldPoly;
        end
        return r;
    endfunction

    function automatic sym_t gf_mul(input sym_t x, input sym_t y);
        sym_t acc;
        sym_t a;
        acc = '0;
        a = x;
        for (int i = 0; i < SymW; i++) begin
            if (y[i]) begin
                acc = acc ^ a;
            end
            a = gf_xtime(a);
        end
        return acc;
    endfunction

endpackage

### rtl/rsp_cell.sv
// One cell of the encoder chain: a generator coefficient, a remainder byte and an
// output byte, sharing one GF(256) multiplier. Depends on rsp_pkg.
module rsp_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  rsp_pkg::rsp_ctrl_t ctrl,
    input  rsp_pkg::sym_t     root,
    input  rsp_pkg::sym_t     coef,
    input  rsp_pkg::sym_t     gen_left,
    output rsp_pkg::sym_t     gen_out,
    input  rsp_pkg::sym_t     rem_right,
    output rsp_pkg::sym_t     rem_out,
    input  rsp_pkg::sym_t     par_right,
    output rsp_pkg::sym_t     par_out
);
    import rsp_pkg::*;

    sym_t gen_reg;
    sym_t gen_next;
    sym_t rem_reg;
    sym_t rem_next;
    sym_t par_reg;
    sym_t par_next;
    sym_t mul_a;
    sym_t mul_b;
    sym_t prod;
    sym_t rem_upd;

    assign mul_a = ctrl.gen_step ? gen_left : gen_reg;
    assign mul_b = ctrl.gen_step ? root : coef;
    assign prod = gf_mul(mul_a, mul_b);
    assign rem_upd = rem_right ^ prod;

    always_comb begin
        gen_next = gen_reg;
        if (ctrl.gen_clear) begin
            gen_next = '0;
        end else if (ctrl.gen_step) begin
            gen_next = gen_reg ^ prod;
        end
        rem_next = rem_reg;
        if (ctrl.load_out) begin
            rem_next = '0;
        end else if (ctrl.data_step) begin
            rem_next = rem_upd;
        end
        par_next = par_reg;
        if (ctrl.load_out) begin
            par_next = rem_upd;
        end else if (ctrl.shift_out) begin
            par_next = par_right;
        end
    end

    always_ff @(posedge aclk) begin
        gen_reg <= gen_next;
        par_reg <= par_next;
        if (!aresetn) begin
            rem_reg <= '0;
        end else begin
            rem_reg <= rem_next;
        end
    end

    assign gen_out = gen_reg;
    assign rem_out = rem_reg;
    assign par_out = par_reg;

endmodule

### rtl/reed_solomon_parity_encoder_top.sv
// Systematic Reed-Solomon parity encoder over GF(256), polynomial 0x11d; depends on rsp_pkg.
// Throughput: one data beat per cycle while s_tready is high. A block's n parity beats start
// the cycle after its last data beat and leave one per cycle while m_tready is high; a last
// data beat waits until the previous block's parity beats have left. After reset, and after
// a parity_count write once any open block has ended, the generator is rebuilt with s_tready
// low (n: clamped count). Reset is synchronous, active low; the parity count returns to 10.
module reed_solomon_parity_encoder_top #(
    parameter int unsigned MAX_PARITY = 32
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [rsp_pkg::CountW-1:0]  cfg_wdata,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,  // [7:0] data_byte
    input  logic                        s_tlast,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [7:0]                  m_tdata,  // [7:0] parity_byte
    output logic                        m_tlast
);
    import rsp_pkg::*;

    localparam int unsigned NW = $clog2(MAX_PARITY + 1);

    logic [CountW-1:0] pc_reg;
    logic [NW-1:0]     n_reg;
    logic [NW-1:0]     n_next;
    logic [NW-1:0]     step_reg;
    logic [NW-1:0]     out_cnt_reg;
    logic              pend_reg;
    logic              build_reg;
    logic              busy_reg;
    logic              rebuild;
    sym_t              root_reg;
    rsp_ctrl_t         ctrl;
    logic              s_acc;
    logic              m_acc;
    logic              out_free;
    sym_t              coef;
    sym_t              gen_c [MAX_PARITY];
    sym_t              rem_c [MAX_PARITY];
    sym_t              par_c [MAX_PARITY];

    always_comb begin
        if (pc_reg == '0) begin
            n_next = NW'(1);
        end else if (int'(pc_reg) > MAX_PARITY) begin
            n_next = NW'(MAX_PARITY);
        end else begin
            n_next = NW'(pc_reg);
        end
    end

    // A new count waits until the block in progress has taken its last beat.
    assign rebuild = pend_reg && !busy_reg;
    assign m_acc = m_tvalid && m_tready;
    assign out_free = (out_cnt_reg == '0) || ((out_cnt_reg == NW'(1)) && m_tready);
    assign s_tready = !rebuild && !build_reg && (!s_tlast || out_free);
    assign s_acc = s_tvalid && s_tready;
    assign coef = s_tdata ^ rem_c[0];

    always_comb begin
        ctrl.gen_clear = rebuild;
        ctrl.gen_step = build_reg;
        ctrl.data_step = s_acc;
        ctrl.load_out = s_acc && s_tlast;
        ctrl.shift_out = m_acc;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= CountReset;
            pend_reg <= 1'b1;
            build_reg <= 1'b0;
            busy_reg <= 1'b0;
            out_cnt_reg <= '0;
            n_reg <= NW'(1);
            step_reg <= '0;
            root_reg <= 8'h01;
        end else begin
            if (cfg_we) begin
                pc_reg <= cfg_wdata;
                pend_reg <= 1'b1;
                build_reg <= 1'b0;
            end else if (rebuild) begin
                pend_reg <= 1'b0;
                build_reg <= 1'b1;
                n_reg <= n_next;
                step_reg <= '0;
                root_reg <= 8'h01;
            end else if (build_reg) begin
                root_reg <= gf_xtime(root_reg);
                step_reg <= step_reg + NW'(1);
                if (step_reg == n_reg - NW'(1)) begin
                    build_reg <= 1'b0;
                end
            end
            if (s_acc) begin
                busy_reg <= !s_tlast;
            end
            if (ctrl.load_out) begin
                out_cnt_reg <= n_reg;
            end else if (m_acc) begin
                out_cnt_reg <= out_cnt_reg - NW'(1);
            end
        end
    end

    for (genvar j = 0; j < MAX_PARITY; j++) begin : g_cell
        sym_t gen_l;
        sym_t rem_r;
        sym_t par_r;

        if (j == 0) begin : g_first
            assign gen_l = 8'h01;
        end else begin : g_mid
            assign gen_l = gen_c[j-1];
        end

        if (j == MAX_PARITY - 1) begin : g_end
            assign rem_r = '0;
            assign par_r = '0;
        end else begin : g_inner
            assign rem_r = rem_c[j+1];
            assign par_r = par_c[j+1];
        end

        rsp_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (ctrl),
            .root      (root_reg),
            .coef      (coef),
            .gen_left  (gen_l),
            .gen_out   (gen_c[j]),
            .rem_right (rem_r),
            .rem_out   (rem_c[j]),
            .par_right (par_r),
            .par_out   (par_c[j])
        );
    end

    assign m_tvalid = out_cnt_reg != '0;
    assign m_tlast = out_cnt_reg == NW'(1);
    assign m_tdata = par_c[0];

endmodule

### dv/reed_solomon_parity_encoder_checker.sv
// Scoreboard for the Reed-Solomon parity encoder: watches the configuration port and
// both stream channels, computes the expected parity beats and compares them in order.
// Depends on rsp_pkg for the symbol and count widths.
`timescale 1ns / 1ps
module reed_solomon_parity_encoder_checker #(
    parameter int unsigned MAX_PARITY = 32
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [rsp_pkg::CountW-1:0]  cfg_wdata,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic [7:0]                  s_tdata,
    input  logic                        s_tlast,
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [7:0]                  m_tdata,
    input  logic                        m_tlast,
    output int                          error_count,
    output int                          pending
);

    typedef struct packed {
        rsp_pkg::sym_t parity;
        logic          is_last;
    } parity_beat_t;

    parity_beat_t                parity_q[$];
    logic [rsp_pkg::CountW-1:0]  count_reg;
    rsp_pkg::sym_t               gen_poly[MAX_PARITY+1];
    rsp_pkg::sym_t               remainder[MAX_PARITY];
    int unsigned                 block_len;
    logic                        in_block;
    int                          beat_no;

    function automatic rsp_pkg::sym_t field_mult(input rsp_pkg::sym_t x, input rsp_pkg::sym_t y);
        logic [8:0]    a;
        rsp_pkg::sym_t acc;
        acc = '0;
        a = {1'b0, x};
        for (int i = 0; i < 8; i++) begin
            if (y[i]) begin
                acc = acc ^ a[7:0];
            end
            a = a << 1;
            if (a[8]) begin
                a = a ^ 9'h11d;
            end
        end
        return acc;
    endfunction

    function automatic int unsigned effective_count(input logic [rsp_pkg::CountW-1:0] c);
        if (c == 0) begin
            return 1;
        end
        if (c > MAX_PARITY) begin
            return MAX_PARITY;
        end
        return 32'(c);
    endfunction

    // The generator is the product of (x - alpha^i) for i below n, alpha = 2.
    task build_generator(input int unsigned n);
        rsp_pkg::sym_t root;
        root = 8'h01;
        for (int unsigned j = 0; j <= MAX_PARITY; j++) begin
            gen_poly[j] = '0;
        end
        gen_poly[0] = 8'h01;
        for (int unsigned i = 0; i < n; i++) begin
            for (int unsigned j = n; j > 0; j--) begin
                gen_poly[j] = gen_poly[j-1] ^ field_mult(gen_poly[j], root);
            end
            gen_poly[0] = field_mult(gen_poly[0], root);
            root = field_mult(root, 8'h02);
        end
    endtask

    task absorb_byte(input rsp_pkg::sym_t d, input logic is_last);
        rsp_pkg::sym_t fb;
        parity_beat_t  pb;
        if (!in_block) begin
            block_len = effective_count(count_reg);
            build_generator(block_len);
            in_block = 1'b1;
        end
        fb = d ^ remainder[0];
        for (int unsigned j = 0; j + 1 < block_len; j++) begin
            remainder[j] = remainder[j+1];
        end
        remainder[block_len-1] = '0;
        if (fb != 0) begin
            for (int unsigned j = 0; j < block_len; j++) begin
                remainder[j] = remainder[j] ^ field_mult(gen_poly[block_len-1-j], fb);
            end
        end
        if (is_last) begin
            for (int unsigned j = 0; j < block_len; j++) begin
                pb.parity = remainder[j];
                pb.is_last = (j + 1 == block_len);
                parity_q.push_back(pb);
            end
            for (int unsigned j = 0; j < MAX_PARITY; j++) begin
                remainder[j] = '0;
            end
            in_block = 1'b0;
        end
    endtask

    task report(input string msg);
        if (error_count < 50) begin
            $display("%0t: parity beat %0d: %s", $realtime, beat_no, msg);
        end
        error_count++;
    endtask

    always @(posedge aclk) begin
        parity_beat_t exp_beat;
        if (!aresetn) begin
            parity_q.delete();
            error_count = 0;
            count_reg = rsp_pkg::CountReset;
            in_block = 1'b0;
            block_len = 1;
            beat_no = 0;
            for (int unsigned j = 0; j < MAX_PARITY; j++) begin
                remainder[j] = '0;
            end
        end else begin
            if (m_tvalid && m_tready) begin
                if (parity_q.size() == 0) begin
                    report($sformatf("unexpected beat %02h last %0b", m_tdata, m_tlast));
                end else begin
                    exp_beat = parity_q.pop_front();
                    if (m_tdata !== exp_beat.parity) begin
                        report($sformatf("parity %02h, expected %02h", m_tdata, exp_beat.parity));
                    end
                    if (m_tlast !== exp_beat.is_last) begin
                        report($sformatf("tlast %0b, expected %0b", m_tlast, exp_beat.is_last));
                    end
                end
                beat_no++;
            end
            if (cfg_we) begin
                count_reg = cfg_wdata;
            end
            if (s_tvalid && s_tready) begin
                absorb_byte(s_tdata, s_tlast);
            end
        end
        pending <= parity_q.size();
    end

endmodule

### dv/reed_solomon_parity_encoder_top_tb.sv
// Testbench top for the Reed-Solomon parity encoder: drives message blocks and parity
// count writes, applies back-pressure, and gives the verdict from the checker's count.
// Depends on rsp_pkg, reed_solomon_parity_encoder_top and reed_solomon_parity_encoder_checker.
`timescale 1ns / 1ps
module reed_solomon_parity_encoder_top_tb;

    logic                        aclk = 1'b0;
    logic                        aresetn = 1'b0;
    logic                        cfg_we = 1'b0;
    logic [rsp_pkg::CountW-1:0]  cfg_wdata = '0;
    logic                        s_tvalid = 1'b0;
    logic                        s_tready;
    logic [7:0]                  s_tdata = '0;
    logic                        s_tlast = 1'b0;
    logic                        m_tvalid;
    logic                        m_tready = 1'b0;
    logic [7:0]                  m_tdata;
    logic                        m_tlast;
    int                          error_count;
    int                          pending;
    bit                          tx_noise = 1'b1;
    bit                          rx_noise = 1'b1;
    bit                          hold_req = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    reed_solomon_parity_encoder_top #(
        .MAX_PARITY(32)
    ) DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tlast(s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast)
    );

    reed_solomon_parity_encoder_checker #(
        .MAX_PARITY(32)
    ) u_checker (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tlast(s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast),
        .error_count(error_count),
        .pending(pending)
    );

    task automatic send_byte(input logic [7:0] d, input logic is_last);
        int gap;
        gap = 0;
        if (tx_noise && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 5);
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= d;
        s_tlast <= is_last;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_block(input int len);
        for (int i = 0; i < len; i++) begin
            send_byte(8'($urandom_range(0, 255)), i == len - 1);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_count(input logic [rsp_pkg::CountW-1:0] v);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        bit held;
        held = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req && !held) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (200) @(posedge aclk);
                m_tready <= 1'b1;
            end else if (rx_noise && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        logic [rsp_pkg::CountW-1:0] phase_count;
        int                         sent;
        int                         len;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        send_byte(8'h00, 1'b1);
        send_byte(8'hff, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b1);
        set_count(6'd0);
        send_byte(8'ha5, 1'b1);
        send_byte(8'hff, 1'b0);
        send_byte(8'h00, 1'b1);
        set_count(6'd63);
        send_byte(8'hff, 1'b0);
        send_byte(8'h55, 1'b1);
        set_count(6'd33);
        send_byte(8'h5a, 1'b1);
        set_count(6'd32);
        send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b1);
        set_count(6'd1);
        send_byte(8'h12, 1'b1);
        set_count(6'd2);
        send_byte(8'h01, 1'b0);
        send_byte(8'h02, 1'b1);

        for (int p = 0; p < 6; p++) begin
            case (p)
                0: phase_count = 6'($urandom_range(1, 32));
                1: phase_count = 6'd32;
                2: phase_count = 6'd16;
                3: phase_count = 6'($urandom_range(0, 63));
                4: phase_count = 6'd1;
                default: phase_count = 6'd10;
            endcase
            if (p == 5) begin
                tx_noise = 1'b0;
                rx_noise = 1'b0;
            end
            set_count(phase_count);
            if (p == 1) begin
                hold_req = 1'b1;
            end
            sent = 0;
            while (sent < 60) begin
                len = ($urandom_range(0, 7) == 0) ? int'($urandom_range(13, 40))
                                                  : int'($urandom_range(1, 12));
                send_block(len);
                sent += len;
            end
        end

        drain();
        repeat (32) @(posedge aclk);
        if (error_count == 0 && pending == 0) begin
            $display("reed_solomon_parity_encoder_top_tb OK");
        end else begin
            $display("reed_solomon_parity_encoder_top_tb NOT OK");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("reed_solomon_parity_encoder_top_tb NOT OK");
        $finish;
    end

endmodule
